// ===== hw/rtl/mbps_pkg.sv =====
// shared types and constants for the masked byte pattern search
package mbps_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int PAT_SLOTS   = 16;
    localparam int OFFSET_W    = 32;
    localparam int LEN_REG_W   = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARE_MASK    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 8'd3;

    // row control, shared by every cell
    typedef struct packed {
        logic shift;
        logic clear;
    } mbps_ctl_t;

    // pattern bytes (byte 0 lowest) and care bits
    typedef struct packed {
        logic [PAT_SLOTS*8-1:0] pattern;
        logic [PAT_SLOTS-1:0]   care;
    } mbps_pat_t;

endpackage

// ===== hw/rtl/mbps_cell.sv =====
// one window cell: holds a byte, passes it on, and checks the byte entering it against its pattern slot
module mbps_cell #(
    parameter int CELL_INDEX = 0,
    parameter int LEN_W      = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mbps_pkg::mbps_ctl_t   ctl,
    input  logic [LEN_W-1:0]      len,
    input  mbps_pkg::mbps_pat_t   pat,
    input  logic [7:0]            byte_in,
    output logic [7:0]            byte_out,
    output logic                  hit
);

    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic [LEN_W-1:0] pos;
    logic [31:0]      pos_ext;
    logic [3:0]       slot;
    logic             active;
    logic             in_range;
    logic             cares;
    logic [7:0]       expected;

    // this cell sees pattern position len-1-index once the new byte is in
    assign active   = LEN_W'(CELL_INDEX) < len;
    assign pos      = len - LEN_W'(CELL_INDEX) - LEN_W'(1);
    assign pos_ext  = 32'(pos);
    assign in_range = pos_ext < 32'(mbps_pkg::PAT_SLOTS);
    assign slot     = pos_ext[3:0];
    assign cares    = active && in_range && pat.care[slot];
    assign expected = pat.pattern[slot*8 +: 8];

    // compare against the byte that enters this cell on this transfer
    assign hit = !cares || (byte_in == expected);

    always_comb begin
        byte_next = byte_reg;
        if (ctl.clear) begin
            byte_next = 8'd0;
        end else if (ctl.shift) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

// ===== hw/rtl/masked_byte_pattern_search.sv =====
// Masked byte pattern search: takes one region byte per cycle unless a stalled result holds
// the input, with no bubbles between items or regions, and returns one result per region:
// found with the start offset of the first match, or not found when the last byte passes
// with no match. The result of a byte appears on the m_ channel in the cycle after its
// transfer: one pass through the row of window cells, whose compares all run in parallel,
// then one output register. A new byte is taken only while the output register is empty
// or hands its result on in the same cycle, so a stalled result stalls the input.
// Configuration must be written only while the block is idle; the block does not enforce it.
module masked_byte_pattern_search #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    input  logic                                 s_region_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_found,
    output logic [mbps_pkg::OFFSET_W-1:0]        m_match_offset
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [63:0]                       pat_low_reg;
    logic [63:0]                       pat_high_reg;
    logic [15:0]                       care_reg;
    logic [mbps_pkg::LEN_REG_W-1:0]    len_cfg_reg;

    logic [mbps_pkg::OFFSET_W-1:0]     seen_reg;
    logic [mbps_pkg::OFFSET_W-1:0]     seen_next;
    logic                              matched_reg;
    logic                              matched_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              out_found_reg;
    logic                              out_found_next;
    logic [mbps_pkg::OFFSET_W-1:0]     out_offset_reg;
    logic [mbps_pkg::OFFSET_W-1:0]     out_offset_next;

    logic [31:0]                       len_wide;
    logic [LEN_W-1:0]                  len;
    logic [mbps_pkg::OFFSET_W-1:0]     len_ext;
    logic                              fire;
    logic                              window_full;
    logic                              all_hit;
    logic                              hit;
    logic                              emit;

    mbps_pkg::mbps_ctl_t               ctl;
    mbps_pkg::mbps_pat_t               pat;
    logic [7:0]                        chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0]            cell_hit;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            len_cfg_reg  <= mbps_pkg::LEN_REG_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                mbps_pkg::CFG_PATTERN_LOW:  pat_low_reg  <= cfg_wdata;
                mbps_pkg::CFG_PATTERN_HIGH: pat_high_reg <= cfg_wdata;
                mbps_pkg::CFG_CARE_MASK:    care_reg     <= cfg_wdata[15:0];
                mbps_pkg::CFG_PATTERN_LEN:  len_cfg_reg  <= cfg_wdata[mbps_pkg::LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the window depth
    always_comb begin
        if (len_cfg_reg == '0) begin
            len_wide = 32'd1;
        end else if (32'(len_cfg_reg) > 32'(PATTERN_MAX)) begin
            len_wide = 32'(PATTERN_MAX);
        end else begin
            len_wide = 32'(len_cfg_reg);
        end
    end
    assign len     = len_wide[LEN_W-1:0];
    assign len_ext = mbps_pkg::OFFSET_W'(len);

    assign pat.pattern = {pat_high_reg, pat_low_reg};
    assign pat.care    = care_reg;

    assign s_ready = !out_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    assign ctl.shift = fire;
    assign ctl.clear = fire && s_region_last;

    assign chain[0] = s_data_byte;

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        mbps_cell #(
            .CELL_INDEX (i),
            .LEN_W      (LEN_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .len      (len),
            .pat      (pat),
            .byte_in  (chain[i]),
            .byte_out (chain[i+1]),
            .hit      (cell_hit[i])
        );
    end

    // saturating byte count, this byte included
    assign seen_next   = (seen_reg == '1) ? seen_reg : seen_reg + mbps_pkg::OFFSET_W'(1);
    assign window_full = seen_next >= len_ext;
    assign all_hit     = &cell_hit;
    assign hit         = !matched_reg && window_full && all_hit;
    assign emit        = hit || (s_region_last && !matched_reg);

    always_comb begin
        matched_next    = matched_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_offset_next = out_offset_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (fire) begin
            matched_next = s_region_last ? 1'b0 : (matched_reg || hit);
            if (emit) begin
                out_valid_next  = 1'b1;
                out_found_next  = hit;
                out_offset_next = hit ? (seen_next - len_ext) : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= '0;
            matched_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                seen_reg <= s_region_last ? '0 : seen_next;
            end
            matched_reg   <= matched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_found_reg  <= out_found_next;
        out_offset_reg <= out_offset_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_found        = out_found_reg;
    assign m_match_offset = out_offset_reg;

endmodule

// ===== hw/rtl/mbps_checker.sv =====
// port-level checks for the masked byte pattern search, bound to the top level
module mbps_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_found,
    input logic [mbps_pkg::OFFSET_W-1:0]  m_match_offset
);

    // a waiting result holds its fields
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_match_offset))
        else $error("result changed while stalled");

    // not-found results carry a zero offset
    a_nf_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_match_offset == '0)
        else $error("not-found result with nonzero offset");

    // no new byte while a result is stuck in the output register
    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // a new result only follows an input transfer
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result without an input transfer");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_found        (m_found),
    .m_match_offset (m_match_offset)
);

// ===== bench/tb_masked_byte_pattern_search.sv =====
// testbench for masked_byte_pattern_search: directed and random regions checked against a predictor
module tb_masked_byte_pattern_search;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam logic [mbps_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 8'hff;

    typedef struct packed {
        logic                          found;
        logic [mbps_pkg::OFFSET_W-1:0] offset;
    } scan_result_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_we;
    logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                             s_valid;
    logic                             s_ready;
    logic [7:0]                       s_data_byte;
    logic                             s_region_last;
    logic                             m_valid;
    logic                             m_ready;
    logic                             m_found;
    logic [mbps_pkg::OFFSET_W-1:0]    m_match_offset;

    // predictor copy of the registers and the scan state
    logic [63:0]                    pat_low;
    logic [63:0]                    pat_high;
    logic [15:0]                    care_bits;
    logic [mbps_pkg::LEN_REG_W-1:0] len_reg;
    logic [7:0]                     window [mbps_pkg::PAT_SLOTS];
    logic [mbps_pkg::OFFSET_W-1:0]  bytes_seen;
    logic                           match_seen;

    scan_result_t expected_results[$];
    int failures      = 0;
    int cycle_count   = 0;
    int items_sent    = 0;
    int hold_request  = 0;
    bit steady_flow   = 1'b0;

    masked_byte_pattern_search dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_region_last (s_region_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_match_offset(m_match_offset)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic int active_length();
        int n;
        n = len_reg;
        if (n < 1) n = 1;
        if (n > mbps_pkg::PAT_SLOTS) n = mbps_pkg::PAT_SLOTS;
        return n;
    endfunction

    function automatic logic [7:0] pattern_byte(int p);
        logic [127:0] all_bytes;
        all_bytes = {pat_high, pat_low};
        return all_bytes[8*p +: 8];
    endfunction

    function automatic void clear_scan();
        for (int i = 0; i < mbps_pkg::PAT_SLOTS; i++) window[i] = 8'h00;
        bytes_seen = '0;
        match_seen = 1'b0;
    endfunction

    // advance the scan by one byte and queue the result it causes, if any
    function automatic void scan_byte(logic [7:0] b, logic last);
        int           len;
        logic         hit;
        scan_result_t r;
        len = active_length();
        for (int i = mbps_pkg::PAT_SLOTS - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = b;
        if (bytes_seen != '1) bytes_seen++;
        if (!match_seen && bytes_seen >= len) begin
            hit = 1'b1;
            // window[0] is the newest byte, so pattern byte 0 sits at the oldest slot
            for (int p = 0; p < len; p++)
                if (care_bits[p] && window[len-1-p] != pattern_byte(p)) hit = 1'b0;
            if (hit) begin
                match_seen = 1'b1;
                r.found = 1'b1;
                r.offset = bytes_seen - mbps_pkg::OFFSET_W'(len);
                expected_results.push_back(r);
            end
        end
        if (last) begin
            if (!match_seen) begin
                r.found = 1'b0;
                r.offset = '0;
                expected_results.push_back(r);
            end
            clear_scan();
        end
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(logic [mbps_pkg::CFG_INDEX_W-1:0] idx,
                             logic [mbps_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            mbps_pkg::CFG_PATTERN_LOW:  pat_low = data;
            mbps_pkg::CFG_PATTERN_HIGH: pat_high = data;
            mbps_pkg::CFG_CARE_MASK:    care_bits = data[15:0];
            mbps_pkg::CFG_PATTERN_LEN:  len_reg = data[mbps_pkg::LEN_REG_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_pattern(logic [63:0] lo, logic [63:0] hi, logic [63:0] care_word,
                               logic [63:0] len_word);
        write_reg(mbps_pkg::CFG_PATTERN_LOW, lo);
        write_reg(mbps_pkg::CFG_PATTERN_HIGH, hi);
        write_reg(mbps_pkg::CFG_CARE_MASK, care_word);
        write_reg(mbps_pkg::CFG_PATTERN_LEN, len_word);
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        release_input();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // only called between regions; after the results drain it also lets bytes that cause nothing settle
    task automatic wait_idle();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = steady_flow ? 0 : pause_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_region_last <= last;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        scan_byte(b, last);
        items_sent++;
    endtask

    task automatic send_region(logic [7:0] bytes[$], int pause_at);
        for (int i = 0; i < bytes.size(); i++) begin
            if (i == pause_at) wait_results_drained();
            send_byte(bytes[i], i == bytes.size() - 1);
        end
    endtask

    task automatic test_reset_state();
        logic [7:0] region[$];
        // reset config: length one, every position a wildcard, so the first byte matches
        region = '{8'hab};
        send_region(region, -1);
        region = '{8'h01, 8'h02};
        send_region(region, -1);
    endtask

    task automatic test_directed_cases();
        logic [7:0] region[$];
        wait_idle();
        // positions 0 and 2 checked, position 1 wildcard
        set_pattern(64'h0000_0000_00ff_3c00, 64'hffff_ffff_ffff_ffff, 64'h0005, 64'd3);
        region = '{8'h00, 8'h12, 8'hff};
        send_region(region, -1);
        // region shorter than the pattern
        region = '{8'h00, 8'hff};
        send_region(region, -1);
        // early match, then a second match and the last byte stay silent
        region = '{8'h00, 8'h34, 8'hff, 8'h00, 8'h77, 8'hff};
        send_region(region, -1);
        wait_idle();
        write_reg(CFG_UNUSED, 64'hffff_ffff_ffff_ffff);
        // length zero behaves as one
        set_pattern(64'h0000_0000_0000_00ff, 64'h0, 64'h0001, 64'd0);
        region = '{8'hff};
        send_region(region, -1);
        wait_idle();
        // oversized length clamps to sixteen, every position checked
        set_pattern(64'h0706_0504_0302_01ff, 64'h00f0_e0d0_c0b0_a090, 64'hffff, 64'd31);
        region.delete();
        for (int p = 0; p < mbps_pkg::PAT_SLOTS; p++) region.push_back(pattern_byte(p));
        send_region(region, -1);
    endtask

    task automatic test_output_backpressure();
        logic [7:0] region[$];
        wait_idle();
        set_pattern(64'h0, 64'h0, 64'h0, 64'd1);
        steady_flow = 1'b1;
        hold_request = 150;
        // every single-byte region yields a result, so the block fills while m_ready is low
        for (int i = 0; i < 20; i++) begin
            region = '{8'($urandom)};
            send_region(region, -1);
        end
        steady_flow = 1'b0;
    endtask

    task automatic pick_phase_config(int phase);
        logic [63:0] lo, hi, care_word, len_word;
        int          r;
        lo        = {$urandom, $urandom};
        hi        = {$urandom, $urandom};
        care_word = {$urandom, $urandom};
        len_word  = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 45)      len_word[4:0] = 5'($urandom_range(1, 6));
        else if (r < 75) len_word[4:0] = 5'($urandom_range(7, 16));
        else if (r < 90) len_word[4:0] = 5'($urandom_range(17, 31));
        else             len_word[4:0] = 5'd0;
        r = $urandom_range(0, 99);
        if (r < 15)      care_word[15:0] = 16'hffff;
        else if (r < 25) care_word[15:0] = 16'h0000;
        case (phase)
            0: begin
                lo = '0;
                hi = '0;
                care_word[15:0] = 16'hffff;
                len_word[4:0] = 5'd16;
            end
            1: begin
                lo = '1;
                hi = '1;
                care_word[15:0] = 16'h0000;
                len_word[4:0] = 5'd1;
            end
            2: begin
                care_word[15:0] = 16'hffff;
                len_word[4:0] = 5'd31;
            end
            3: len_word[4:0] = 5'd0;
            default: ;
        endcase
        set_pattern(lo, hi, care_word, len_word);
    endtask

    task automatic test_random_regions();
        logic [7:0] region[$];
        int phase, region_count, nb, len, pos, stop_at, pause_at, random_start;
        phase = 0;
        region_count = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            wait_idle();
            pick_phase_config(phase);
            steady_flow = (phase == 3);
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at) begin
                len = active_length();
                nb = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 20) : $urandom_range(21, 70);
                region.delete();
                // half the bytes come from the pattern so partial matches are common
                for (int i = 0; i < nb; i++) begin
                    if ($urandom_range(0, 1) == 1) region.push_back(8'($urandom));
                    else region.push_back(pattern_byte($urandom_range(0, len - 1)));
                end
                if (nb >= len && $urandom_range(0, 9) < 7) begin
                    pos = ($urandom_range(0, 3) == 0) ? nb - len : $urandom_range(0, nb - len);
                    for (int p = 0; p < len; p++)
                        if (care_bits[p]) region[pos+p] = pattern_byte(p);
                end
                pause_at = (region_count % 40 == 5) ? nb / 2 : -1;
                send_region(region, pause_at);
                region_count++;
            end
            phase++;
        end
        steady_flow = 1'b0;
    endtask

    // receiver side: random short and long stalls, or a long hold on request
    initial begin : result_ready
        int gap_left;
        int hold_left;
        gap_left = 0;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (steady_flow) begin
                m_ready <= 1'b1;
            end else if (gap_left > 0) begin
                m_ready <= 1'b0;
                gap_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 4) == 0) gap_left = pause_len();
            end
        end
    end

    always @(posedge aclk) begin : result_check
        scan_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: found %0d match_offset %0d",
                       m_found, m_match_offset);
                failures++;
            end else begin
                want = expected_results.pop_front();
                if (m_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, m_found);
                    failures++;
                end
                if (m_match_offset !== want.offset) begin
                    $error("match_offset: expected %0d, actual %0d", want.offset, m_match_offset);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data_byte   = 8'h00;
        s_region_last = 1'b0;
        pat_low       = '0;
        pat_high      = '0;
        care_bits     = '0;
        len_reg       = mbps_pkg::LEN_REG_W'(1);
        clear_scan();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_directed_cases();
        test_output_backpressure();
        test_random_regions();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
